[hw/rtl/mm_pkg.sv]
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants of the matrix multiply block
// Request and result payloads, controller/datapath command and status,
// request modes and configuration register indexes.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int MAX_DIM_DEF    = 16;
	localparam int ELEM_WIDTH_DEF = 16;

	localparam int MODE_W  = 2;
	localparam int IDX_W   = 4;
	localparam int VALUE_W = 16;
	localparam int RES_W   = 36;
	localparam int DIM_W   = 5;
	localparam int CFG_W   = 2;

	localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	localparam logic [CFG_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_W-1:0] REG_INNER  = 2'd1;
	localparam logic [CFG_W-1:0] REG_COLS_B = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [VALUE_W-1:0] value;
	} mm_in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result;
		logic [IDX_W-1:0]        out_col;
		logic                    last;
	} mm_out_t;

	// controller to datapath
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             issue;
		logic             issue_last;
		logic [DIM_W-1:0] inner;
	} mm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
	} mm_status_t;

	// index width for a dimension of d entries
	function automatic int idx_w(input int d);
		return (d > 1) ? $clog2(d) : 1;
	endfunction

endpackage

[hw/rtl/mm_ram.sv]
// ----------------------------------------------------------------------------
// mm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/mm_ctrl.sv]
// ----------------------------------------------------------------------------
// mm_ctrl: request controller of the matrix multiply block
// Holds the shape registers, decodes requests into element writes and
// sequences one product row as a run of column reads.
// ----------------------------------------------------------------------------
module mm_ctrl #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF,
	localparam int LW = mm_pkg::idx_w(MAX_DIM)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  mm_pkg::mm_in_t               req,
	output logic                         busy,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mm_pkg::CFG_W-1:0]     cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]     cfg_data,
	output mm_pkg::mm_cmd_t              cmd,
	input  mm_pkg::mm_status_t           st,
	output logic [LW-1:0]                wr_bank,
	output logic [LW-1:0]                wr_addr,
	output logic signed [ELEM_WIDTH-1:0] wr_data,
	output logic [LW-1:0]                rd_row,
	output logic [LW-1:0]                rd_col
);
	import mm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]       state_q;
	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] inner_q;
	logic [DIM_W-1:0] cols_q;
	logic [LW-1:0]    row_q;
	logic [LW-1:0]    col_q;
	logic             accept;
	logic             row_ok;
	logic             col_last;
	logic [DIM_W-1:0] cfg_dim;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign row_ok    = DIM_W'(req.row) < rows_q;
	assign col_last  = (int'(col_q) + 1 == int'(cols_q));

	// saturate shape writes at the array size
	assign cfg_dim = (int'(cfg_data) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_data;

	always_comb begin
		cmd.wr_a       = accept && (req.mode == MODE_LOAD_A) && row_ok
		                 && (DIM_W'(req.col) < inner_q);
		cmd.wr_b       = accept && (req.mode == MODE_LOAD_B)
		                 && (DIM_W'(req.row) < inner_q) && (DIM_W'(req.col) < cols_q);
		cmd.issue      = (state_q == ST_RUN);
		cmd.issue_last = col_last;
		cmd.inner      = inner_q;
	end

	// A is banked by column, B by row
	assign wr_bank = (req.mode == MODE_LOAD_A) ? LW'(req.col) : LW'(req.row);
	assign wr_addr = (req.mode == MODE_LOAD_A) ? LW'(req.row) : LW'(req.col);
	assign wr_data = ELEM_WIDTH'(req.value);
	assign rd_row  = row_q;
	assign rd_col  = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_W'(MAX_DIM_DEF > MAX_DIM ? MAX_DIM : MAX_DIM_DEF);
			inner_q <= DIM_W'(MAX_DIM_DEF > MAX_DIM ? MAX_DIM : MAX_DIM_DEF);
			cols_q  <= DIM_W'(MAX_DIM_DEF > MAX_DIM ? MAX_DIM : MAX_DIM_DEF);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS_A: rows_q  <= cfg_dim;
				REG_INNER:  inner_q <= cfg_dim;
				REG_COLS_B: cols_q  <= cfg_dim;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.mode == MODE_COMPUTE) && row_ok && (cols_q != '0)) begin
						row_q   <= LW'(req.row);
						col_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					col_q <= col_q + 1'b1;
					if (col_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold until the last column leaves the datapath
					if (!st.pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/mm_datapath.sv]
// ----------------------------------------------------------------------------
// mm_datapath: element storage and dot-product pipeline
// One A bank and one B bank per inner index, one multiplier per lane and a
// registered adder tree; one product element per cycle.
// ----------------------------------------------------------------------------
module mm_datapath #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF,
	localparam int LW = mm_pkg::idx_w(MAX_DIM)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mm_pkg::mm_cmd_t              cmd,
	input  logic [LW-1:0]                wr_bank,
	input  logic [LW-1:0]                wr_addr,
	input  logic signed [ELEM_WIDTH-1:0] wr_data,
	input  logic [LW-1:0]                rd_row,
	input  logic [LW-1:0]                rd_col,
	output mm_pkg::mm_status_t           st,
	output logic                         rsp_valid,
	output mm_pkg::mm_out_t              rsp
);
	import mm_pkg::*;

	localparam int LVL = $clog2(MAX_DIM);
	localparam int P2  = 1 << LVL;
	localparam int NST = LVL + 2;

	logic [ELEM_WIDTH-1:0]       a_rd    [MAX_DIM];
	logic [ELEM_WIDTH-1:0]       b_rd    [MAX_DIM];
	logic signed [2*ELEM_WIDTH-1:0] mul  [MAX_DIM];
	logic signed [RES_W-1:0]     prod_s2 [MAX_DIM];
	logic signed [RES_W-1:0]     lvl0    [P2];
	logic signed [RES_W-1:0]     tree_q  [1:LVL][P2];
	logic [NST-1:0]              vld_q;
	logic [NST-1:0]              lst_q;
	logic [LW-1:0]               col_q   [NST];

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_lane
		mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM)) u_a (
			.clk   (clk),
			.we    (cmd.wr_a && (wr_bank == LW'(k))),
			.waddr (wr_addr),
			.wdata (wr_data),
			.raddr (rd_row),
			.rdata (a_rd[k])
		);
		mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM)) u_b (
			.clk   (clk),
			.we    (cmd.wr_b && (wr_bank == LW'(k))),
			.waddr (wr_addr),
			.wdata (wr_data),
			.raddr (rd_col),
			.rdata (b_rd[k])
		);

		assign mul[k] = signed'(a_rd[k]) * signed'(b_rd[k]);

		// drop lanes beyond the inner dimension
		always_ff @(posedge clk) begin
			prod_s2[k] <= (int'(cmd.inner) > k) ? RES_W'(mul[k]) : '0;
		end
	end

	for (genvar n = 0; n < P2; n++) begin : g_pad
		if (n < MAX_DIM) begin : g_used
			assign lvl0[n] = prod_s2[n];
		end else begin : g_zero
			assign lvl0[n] = '0;
		end
	end

	for (genvar l = 1; l <= LVL; l++) begin : g_lvl
		for (genvar n = 0; n < (P2 >> l); n++) begin : g_node
			if (l == 1) begin : g_first
				always_ff @(posedge clk) begin
					tree_q[l][n] <= lvl0[2*n] + lvl0[2*n+1];
				end
			end else begin : g_rest
				always_ff @(posedge clk) begin
					tree_q[l][n] <= tree_q[l-1][2*n] + tree_q[l-1][2*n+1];
				end
			end
		end
	end

	// column tag travels alongside the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NST-2:0], cmd.issue};
		end
	end

	always_ff @(posedge clk) begin
		lst_q    <= {lst_q[NST-2:0], cmd.issue_last};
		col_q[0] <= rd_col;
		for (int s = 1; s < NST; s++) begin
			col_q[s] <= col_q[s-1];
		end
	end

	assign st.pipe_busy = |vld_q;
	assign rsp_valid    = vld_q[NST-1];
	assign rsp.result   = tree_q[LVL][0];
	assign rsp.out_col  = IDX_W'(col_q[NST-1]);
	assign rsp.last     = lst_q[NST-1];

endmodule

[hw/rtl/matrix_multiply.sv]
// ----------------------------------------------------------------------------
// matrix_multiply: row-at-a-time product of two stored matrices
// Requests on start/busy load one element of A or B, or compute a product row;
// shape registers are written over the cfg valid/ready channel while idle.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low.
//   A load writes one element in the request cycle; busy never rises, so a
//   new request may follow in the next cycle. Loads outside the shape drop.
//   A compute request for a row inside rows_a, with cols_b nonzero, raises
//   busy and returns cols_b results in column order, one per cycle on rsp
//   with rsp_valid, the last one flagged. Busy stays high until the last result
//   has left the registered RAM read, the product register and the adder tree.
//   Throughput is set by the column sequencer: one product element per
//   cycle, all inner-index lanes multiplied at once and summed in a
//   registered adder tree of log2(MAX_DIM) levels.
//   Results cannot be held off: each stands on rsp for exactly one cycle.
//   Reset restores all shape registers to 16 (saturated at MAX_DIM) and
//   empties the pipeline; matrix contents are undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_multiply #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  mm_pkg::mm_in_t           req,
	output logic                     rsp_valid,
	output mm_pkg::mm_out_t          rsp,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [mm_pkg::CFG_W-1:0] cfg_index,
	input  logic [mm_pkg::DIM_W-1:0] cfg_data
);
	import mm_pkg::*;

	localparam int LW = idx_w(MAX_DIM);

	mm_cmd_t                      cmd;
	mm_status_t                   st;
	logic [LW-1:0]                wr_bank;
	logic [LW-1:0]                wr_addr;
	logic signed [ELEM_WIDTH-1:0] wr_data;
	logic [LW-1:0]                rd_row;
	logic [LW-1:0]                rd_col;

	mm_ctrl #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.wr_bank   (wr_bank),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_row    (rd_row),
		.rd_col    (rd_col)
	);

	mm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_bank   (wr_bank),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_row    (rd_row),
		.rd_col    (rd_col),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_rsp_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> busy)
		else $error("result strobe outside a compute");

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.mode != MODE_COMPUTE)) |=> !busy)
		else $error("non-compute request raised busy");

	a_row_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |=>
		(rsp_valid && (rsp.out_col == IDX_W'($past(rsp.out_col) + 1'b1))))
		else $error("gap or column skip inside a product row");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |=> !rsp_valid)
		else $error("result after the last column");

endmodule

[tb/sv/mm_row_checker.sv]
// ----------------------------------------------------------------------------
// mm_row_checker: product row predictor and result checker
// Watches the request, configuration and result channels of matrix_multiply.
// It keeps its own copy of the shape registers and of both matrices, works
// out every product row that an accepted compute request must return, and
// compares each result on rsp against the oldest outstanding product element.
// ----------------------------------------------------------------------------
module mm_row_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  mm_pkg::mm_in_t           req,
	input  logic                     rsp_valid,
	input  mm_pkg::mm_out_t          rsp,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [mm_pkg::CFG_W-1:0] cfg_index,
	input  logic [mm_pkg::DIM_W-1:0] cfg_data,
	output int                       errors,
	output int                       pending,
	output int                       checked
);
	import mm_pkg::*;

	localparam int DIM         = MAX_DIM_DEF;
	localparam int MAX_REPORTS = 10;

	logic [DIM_W-1:0]          rows_a;
	logic [DIM_W-1:0]          inner;
	logic [DIM_W-1:0]          cols_b;
	logic signed [VALUE_W-1:0] elem_a [DIM][DIM];
	logic signed [VALUE_W-1:0] elem_b [DIM][DIM];
	mm_out_t                   product_q [$];

	// saturate a shape write at the array size
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return (d > DIM) ? DIM_W'(DIM) : d;
	endfunction

	task automatic predict_row(input logic [IDX_W-1:0] r);
		logic signed [RES_W-1:0] acc;
		mm_out_t                 elem;
		for (int j = 0; j < cols_b; j++) begin
			acc = '0;
			for (int k = 0; k < inner; k++)
				acc = acc + elem_a[r][k] * elem_b[k][j];
			elem.result  = acc;
			elem.out_col = IDX_W'(j);
			elem.last    = (j + 1 == cols_b);
			product_q.push_back(elem);
		end
	endtask

	task automatic take_request(input mm_in_t item);
		case (item.mode)
			MODE_LOAD_A: begin
				if (item.row < rows_a && item.col < inner)
					elem_a[item.row][item.col] = item.value;
			end
			MODE_LOAD_B: begin
				if (item.row < inner && item.col < cols_b)
					elem_b[item.row][item.col] = item.value;
			end
			MODE_COMPUTE: begin
				if (item.row < rows_a)
					predict_row(item.row);
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input mm_out_t got);
		mm_out_t want;
		checked++;
		if (product_q.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("unexpected result: result %0d out_col %0d last %0d",
					got.result, got.out_col, got.last);
			return;
		end
		want = product_q.pop_front();
		if (got.result !== want.result || got.out_col !== want.out_col ||
				got.last !== want.last) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display({"result mismatch: expected result %0d out_col %0d last %0d,",
					" got result %0d out_col %0d last %0d"},
					want.result, want.out_col, want.last,
					got.result, got.out_col, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a  = DIM_W'(DIM);
			inner   = DIM_W'(DIM);
			cols_b  = DIM_W'(DIM);
			product_q.delete();
			pending = 0;
		end else begin
			if (rsp_valid)
				check_result(rsp);
			// a request taken on this edge still sees the old shape
			if (start && !busy)
				take_request(req);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS_A: rows_a = clamp_dim(cfg_data);
					REG_INNER:  inner  = clamp_dim(cfg_data);
					REG_COLS_B: cols_b = clamp_dim(cfg_data);
					default: ;
				endcase
			end
			pending = product_q.size();
		end
	end

endmodule

[tb/sv/matrix_multiply_tb.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_tb: stimulus and verdict for the matrix multiply block
// Loads elements of A and B and asks for product rows under a series of
// shapes, from empty and single dimensions up to saturated ones. A short
// directed opening hits the value extremes and every ignored case; random
// phases follow. Results are checked by mm_row_checker.
// ----------------------------------------------------------------------------
module matrix_multiply_tb;
	import mm_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_TARGET = 250;
	localparam int PHASE_UNITS   = 30;
	localparam int IDLE_PCT      = 32;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int DIM           = MAX_DIM_DEF;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_W-1:0]  REG_UNUSED  = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	mm_in_t           req;
	logic             rsp_valid;
	mm_out_t          rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;

	int chk_errors;
	int chk_pending;
	int chk_results;

	// stimulus view of the shape and of which elements hold data
	int shape_rows  = DIM;
	int shape_inner = DIM;
	int shape_cols  = DIM;
	bit loaded_a [DIM][DIM];
	bit loaded_b [DIM][DIM];

	int n_sent     = 0;
	int n_useful   = 0;
	int n_rows     = 0;
	int n_cfg      = 0;
	int cycle_cnt  = 0;
	bit calm       = 0;
	bit extreme_on = 0;

	matrix_multiply i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mm_row_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (chk_errors),
		.pending   (chk_pending),
		.checked   (chk_results)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[matrix_multiply] ERROR");
			$finish;
		end
	end

	function automatic int eff_dim(input logic [DIM_W-1:0] d);
		return (d > DIM) ? DIM : int'(d);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		if (extreme_on || $urandom_range(99) < 15) begin
			case ($urandom_range(4))
				0:       return 16'h8000;
				1:       return 16'h7FFF;
				2:       return 16'hFFFF;
				3:       return 16'h0000;
				default: return 16'h0100;
			endcase
		end
		return VALUE_W'($urandom);
	endfunction

	// keep most shapes small so filling B stays cheap
	function automatic logic [DIM_W-1:0] pick_dim(input bit big);
		if (big)
			return ($urandom_range(2) == 0) ? DIM_W'($urandom_range(17, 31)) : DIM_W'(DIM);
		if ($urandom_range(99) < 8)
			return '0;
		return DIM_W'($urandom_range(1, 4));
	endfunction

	task automatic send_req(input logic [MODE_W-1:0] mode, input int row, input int col,
			input logic [VALUE_W-1:0] value);
		mm_in_t item;
		item.mode  = mode;
		item.row   = IDX_W'(row);
		item.col   = IDX_W'(col);
		item.value = value;
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		n_sent++;
		case (mode)
			MODE_LOAD_A: begin
				if (row < shape_rows && col < shape_inner) begin
					loaded_a[row][col] = 1'b1;
					n_useful++;
				end
			end
			MODE_LOAD_B: begin
				if (row < shape_inner && col < shape_cols) begin
					loaded_b[row][col] = 1'b1;
					n_useful++;
				end
			end
			MODE_COMPUTE: begin
				if (row < shape_rows) begin
					n_useful++;
					n_rows++;
				end
			end
			default: ;
		endcase
		calm = (n_useful >= 150 && n_useful < 230);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// load whatever the row needs that was never written, then ask for it
	task automatic compute_row(input int row);
		if (row < shape_rows) begin
			for (int k = 0; k < shape_inner; k++)
				if (!loaded_a[row][k])
					send_req(MODE_LOAD_A, row, k, pick_value());
			for (int k = 0; k < shape_inner; k++)
				for (int j = 0; j < shape_cols; j++)
					if (!loaded_b[k][j])
						send_req(MODE_LOAD_B, k, j, pick_value());
		end
		send_req(MODE_COMPUTE, row, $urandom_range(15), VALUE_W'($urandom));
	endtask

	task automatic reload_element();
		if ($urandom_range(1) == 0) begin
			if (shape_rows > 0 && shape_inner > 0)
				send_req(MODE_LOAD_A, $urandom_range(shape_rows - 1),
					$urandom_range(shape_inner - 1), pick_value());
		end else if (shape_inner > 0 && shape_cols > 0) begin
			send_req(MODE_LOAD_B, $urandom_range(shape_inner - 1),
				$urandom_range(shape_cols - 1), pick_value());
		end
	endtask

	// drain: nothing outstanding, then cover the pipeline depth
	task automatic settle();
		start <= 1'b0;
		repeat (2) @(posedge clk);
		while (chk_pending != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		n_cfg++;
		case (idx)
			REG_ROWS_A: shape_rows  = eff_dim(data);
			REG_INNER:  shape_inner = eff_dim(data);
			REG_COLS_B: shape_cols  = eff_dim(data);
			default: ;
		endcase
		if ($urandom_range(99) < IDLE_PCT) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic set_shape(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] inn,
			input logic [DIM_W-1:0] cb, input bit spare);
		settle();
		if (spare)
			write_reg(REG_UNUSED, DIM_W'($urandom));
		write_reg(REG_ROWS_A, ra);
		write_reg(REG_INNER, inn);
		write_reg(REG_COLS_B, cb);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int target;
		int big;
		int sel;
		int m;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the element range, then every ignored request
		set_shape(5'd2, 5'd3, 5'd2, 1'b1);
		send_req(MODE_LOAD_A, 0, 0, 16'h7FFF);
		send_req(MODE_LOAD_A, 0, 1, 16'h8000);
		send_req(MODE_LOAD_A, 0, 2, 16'h0100);
		send_req(MODE_LOAD_B, 0, 0, 16'h8000);
		send_req(MODE_LOAD_B, 0, 1, 16'h7FFF);
		send_req(MODE_LOAD_B, 1, 0, 16'hFFFF);
		send_req(MODE_LOAD_B, 1, 1, 16'h0000);
		send_req(MODE_LOAD_B, 2, 0, 16'h0080);
		send_req(MODE_LOAD_B, 2, 1, 16'h8000);
		compute_row(0);
		send_req(MODE_LOAD_A, 2, 0, 16'h1234);
		send_req(MODE_LOAD_A, 1, 3, 16'h1234);
		send_req(MODE_LOAD_B, 3, 0, 16'h1234);
		send_req(MODE_LOAD_B, 0, 2, 16'h1234);
		send_req(MODE_UNUSED, 0, 0, 16'h1234);
		compute_row(2);
		compute_row(15);
		compute_row(1);

		// empty dimensions: zero inner gives zero sums, zero rows or columns give nothing
		set_shape(5'd1, 5'd0, 5'd3, 1'b0);
		compute_row(0);
		set_shape(5'd0, 5'd2, 5'd2, 1'b0);
		send_req(MODE_LOAD_A, 0, 0, 16'h4000);
		compute_row(0);
		set_shape(5'd2, 5'd2, 5'd0, 1'b0);
		compute_row(1);

		// shape writes above the array size saturate
		set_shape(5'd31, 5'd1, 5'd17, 1'b0);
		compute_row(15);

		target = n_useful + RANDOM_TARGET;
		while (n_useful < target) begin
			big        = $urandom_range(4);
			extreme_on = ($urandom_range(3) == 0);
			set_shape(pick_dim(big == 0), pick_dim(big == 1), pick_dim(big == 2),
				$urandom_range(3) == 0);
			for (int unit = 0; unit < PHASE_UNITS && n_useful < target; unit++) begin
				sel = $urandom_range(99);
				if (sel < 65) begin
					repeat ($urandom_range(2)) reload_element();
					compute_row(shape_rows > 0 ? $urandom_range(shape_rows - 1)
						: $urandom_range(15));
				end else if (sel < 80) begin
					compute_row($urandom_range(15));
				end else begin
					m = $urandom_range(3);
					if (m == MODE_COMPUTE)
						compute_row($urandom_range(15));
					else
						send_req(MODE_W'(m), $urandom_range(15), $urandom_range(15),
							VALUE_W'($urandom));
				end
			end
		end

		settle();
		$display("run covered %0d requests (%0d in shape, %0d product rows)",
			n_sent, n_useful, n_rows);
		$display("and %0d register writes; %0d results compared, %0d mismatches, %0d never arrived",
			n_cfg, chk_results, chk_errors, chk_pending);
		if (chk_errors == 0 && chk_pending == 0)
			$display("[matrix_multiply] OK");
		else
			$display("[matrix_multiply] ERROR");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/mm_pkg.sv
hw/rtl/mm_ram.sv
hw/rtl/mm_ctrl.sv
hw/rtl/mm_datapath.sv
hw/rtl/matrix_multiply.sv
tb/sv/mm_row_checker.sv
tb/sv/matrix_multiply_tb.sv
